@@ design/pal_pkg.sv @@
// Shared types and constants for the positional array list.
package pal_pkg;

    localparam int FUNC_W    = 2;
    localparam int POS_W     = 8;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 7;
    localparam int CAP_W     = 7;
    localparam int IN_W      = 48;
    localparam int OUT_W     = 48;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_GET    = 2'd2,
        FUNC_LOCATE = 2'd3
    } t_func;

    // broadcast to every cell
    typedef struct packed {
        logic ins;  // shift up from the insert point, load value there
        logic del;  // shift down from the delete point
    } t_cell_ctl;

endpackage

@@ design/pal_cell.sv @@
// One storage cell of the list: holds one entry and trades it with its neighbors.
module pal_cell #(
    parameter int IDX = 0,
    parameter int XW  = 9
) (
    input  logic                     i_clk,
    input  pal_pkg::t_cell_ctl       i_ctl,
    input  logic [XW-1:0]            i_pidx,    // 0-based position
    input  logic [XW-1:0]            i_count,
    input  logic [pal_pkg::VAL_W-1:0] i_value,
    input  logic [pal_pkg::VAL_W-1:0] i_left,   // entry of cell IDX-1
    input  logic [pal_pkg::VAL_W-1:0] i_right,  // entry of cell IDX+1
    output logic [pal_pkg::VAL_W-1:0] o_entry,
    output logic [pal_pkg::VAL_W-1:0] o_rd,     // entry if addressed, else 0
    output logic                     o_match
);
    import pal_pkg::*;

    localparam logic [XW-1:0] MY_IDX = XW'(IDX);

    logic [VAL_W-1:0] r_entry;
    logic [VAL_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (MY_IDX == i_pidx) begin
                n_entry = i_value;
            end else if (MY_IDX > i_pidx) begin
                n_entry = i_left;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX >= i_pidx) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_rd    = (MY_IDX == i_pidx) ? r_entry : '0;
    assign o_match = (r_entry == i_value) && (MY_IDX < i_count);

endmodule

@@ design/pal_prienc.sv @@
// Priority encoder: index of the lowest set hit bit.
module pal_prienc #(
    parameter int N = 64
) (
    input  logic [N-1:0]         i_hit,
    output logic                 o_any,
    output logic [$clog2(N)-1:0] o_idx
);
    always_comb begin
        o_idx = '0;
        for (int k = N - 1; k >= 0; k--) begin
            if (i_hit[k]) begin
                o_idx = ($clog2(N))'(k);
            end
        end
    end

    assign o_any = |i_hit;

endmodule

@@ design/positional_array_list.sv @@
// Top level of the positional array list: ordered list held in a chain of cells.
//
// Usage:
//   Input beats on the s channel carry func, position and item_value. Each
//   accepted beat produces exactly one result beat on the m channel with
//   status, read_value, found_position and list_count (length after the op).
//   Insert/delete shift the cells from the addressed slot onward toward or
//   away from it; locate compares all cells at once and a priority encoder picks
//   the first hit; get selects the addressed cell through an OR tree.
//   Output: the result of each accepted beat is captured in the output register.
//   Throughput: 1 item per cycle while the m side takes results; the cell
//   update and the match priority encoder span all DEPTH cells.
//   Stall: when the m side holds off, the result stays in the output register
//   and o_s_tready drops until it is taken; a beat may enter in the same cycle
//   the pending result leaves.
//   Configuration: the cfg channel writes capacity (always ready); write it
//   only while no beat is in flight.
//   Reset: list length clears to 0, capacity returns to 64, output register
//   empties. Entry storage is not cleared; only live entries are ever read.
module positional_array_list #(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // capacity write
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pal_pkg::CAP_W-1:0]  i_cfg_data,
    // tdata: func[1:0], position[9:2], item_value[41:10], zero pad
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [pal_pkg::IN_W-1:0]   i_s_tdata,
    // tdata: status[0], read_value[32:1], found_position[39:33],
    //        list_count[46:40], zero pad
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [pal_pkg::OUT_W-1:0]  o_m_tdata
);
    import pal_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);          // list length
    localparam int IW = $clog2(DEPTH);              // cell index
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;  // compare width

    // control state
    logic [CW-1:0]    r_count, n_count;
    logic [CAP_W-1:0] r_cap;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data, n_out_data;

    // input fields
    t_func            in_func;
    logic [POS_W-1:0] in_pos;
    logic [VAL_W-1:0] in_value;
    logic             accept;

    assign in_func  = t_func'(i_s_tdata[1:0]);
    assign in_pos   = i_s_tdata[9:2];
    assign in_value = i_s_tdata[41:10];

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // position checks
    logic [XW-1:0] pos_x, cnt_x, pidx, cap_x, eff_cap;
    logic          pos_nz, ins_ok, rd_ok;

    assign pos_x   = XW'(in_pos);
    assign cnt_x   = XW'(r_count);
    assign pidx    = pos_x - XW'(1);
    assign cap_x   = XW'(r_cap);
    assign eff_cap = (cap_x < XW'(DEPTH)) ? cap_x : XW'(DEPTH);
    assign pos_nz  = (in_pos != '0);
    assign ins_ok  = pos_nz && (pos_x <= cnt_x + XW'(1)) && (cnt_x < eff_cap);
    assign rd_ok   = pos_nz && (pos_x <= cnt_x);

    // cell chain
    t_cell_ctl        ctl;
    logic [VAL_W-1:0] cell_entry [DEPTH];
    logic [VAL_W-1:0] cell_rd    [DEPTH];
    logic [DEPTH-1:0] cell_match;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [VAL_W-1:0] left_d, right_d;
        if (k == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_entry[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_entry[k+1];
        end

        pal_cell #(
            .IDX (k),
            .XW  (XW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_pidx  (pidx),
            .i_count (cnt_x),
            .i_value (in_value),
            .i_left  (left_d),
            .i_right (right_d),
            .o_entry (cell_entry[k]),
            .o_rd    (cell_rd[k]),
            .o_match (cell_match[k])
        );
    end

    // get: only the addressed cell drives nonzero
    logic [VAL_W-1:0] rd_or;
    always_comb begin
        rd_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_or = rd_or | cell_rd[k];
        end
    end

    // locate
    logic          hit_any;
    logic [IW-1:0] hit_idx;
    logic [CW-1:0] found_full;

    pal_prienc #(
        .N (DEPTH)
    ) u_prienc (
        .i_hit (cell_match),
        .o_any (hit_any),
        .o_idx (hit_idx)
    );

    assign found_full = CW'(hit_idx) + CW'(1);

    // operation decode and result
    logic             st;
    logic [VAL_W-1:0] rd_val;
    logic [CW-1:0]    found;

    always_comb begin
        ctl     = '0;
        n_count = r_count;
        st      = 1'b1;
        rd_val  = '0;
        found   = '0;
        case (in_func)
            FUNC_INSERT: begin
                if (ins_ok) begin
                    ctl.ins = accept;
                    n_count = r_count + CW'(1);
                    st      = 1'b0;
                end
            end
            FUNC_DELETE: begin
                if (rd_ok) begin
                    ctl.del = accept;
                    n_count = r_count - CW'(1);
                    st      = 1'b0;
                end
            end
            FUNC_GET: begin
                if (rd_ok) begin
                    rd_val = rd_or;
                    st     = 1'b0;
                end
            end
            FUNC_LOCATE: begin
                if (hit_any) begin
                    found = found_full;
                    st    = 1'b0;
                end
            end
            default: begin
                st = 1'b1;
            end
        endcase
        n_out_data = {1'b0, CNT_OUT_W'(n_count), CNT_OUT_W'(found), rd_val, st};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

@@ tb/sv/positional_array_list_tb.sv @@
// Self-checking stream testbench for the positional array list.
module positional_array_list_tb;
    import pal_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 400000;

    // One expected result beat, fields as they leave the block.
    typedef struct packed {
        logic                 status;
        logic [VAL_W-1:0]     read_value;
        logic [CNT_OUT_W-1:0] found_pos;
        logic [CNT_OUT_W-1:0] length;
    } t_list_result;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CAP_W-1:0]     i_cfg_data  = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [IN_W-1:0]      i_s_tdata   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [OUT_W-1:0]     o_m_tdata;

    // Shadow copy of the list, updated when an input beat is accepted.
    logic [VAL_W-1:0]     shadow_list [LIST_DEPTH];
    int                   shadow_len = 0;
    int                   shadow_cap = CAP_RESET;

    t_list_result         pending_results [$];

    int  mismatches     = 0;
    int  results_seen   = 0;
    int  cycle_count    = 0;
    int  peak_len       = 0;
    int  capacity_writes = 0;
    int  ops_sent [4]   = '{default: 0};
    int  ops_ok   [4]   = '{default: 0};

    // Idle controls: sender gaps, receiver gaps, and a one-shot long hold-off.
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  rx_hold    = 0;

    positional_array_list #(
        .DEPTH (LIST_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),    // func[1:0], position[9:2], item_value[41:10], pad
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)     // status[0], read_value[32:1], found_position[39:33],
                                     // list_count[46:40], pad
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Predictor: apply one op to the shadow list and return the beat it should produce.
    function automatic t_list_result apply_list_op(t_func f, logic [POS_W-1:0] pos,
                                                    logic [VAL_W-1:0] v);
        t_list_result r;
        int           k;
        int           p;
        int           cap_lim;
        r       = '0;
        r.status = 1'b1;
        p       = pos;
        cap_lim = (shadow_cap < LIST_DEPTH) ? shadow_cap : LIST_DEPTH;
        case (f)
            FUNC_INSERT: begin
                if (p >= 1 && p <= shadow_len + 1 && shadow_len < cap_lim) begin
                    for (k = shadow_len; k >= p; k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[p-1] = v;
                    shadow_len++;
                    r.status = 1'b0;
                end
            end
            FUNC_DELETE: begin
                // only live entries move; nothing past the tail is touched
                if (p >= 1 && p <= shadow_len) begin
                    for (k = p - 1; k + 1 < shadow_len; k++)
                        shadow_list[k] = shadow_list[k+1];
                    shadow_len--;
                    r.status = 1'b0;
                end
            end
            FUNC_GET: begin
                if (p >= 1 && p <= shadow_len) begin
                    r.read_value = shadow_list[p-1];
                    r.status     = 1'b0;
                end
            end
            default: begin
                // first match wins; position field is don't-care
                for (k = 0; k < shadow_len; k++) begin
                    if (shadow_list[k] == v) begin
                        r.found_pos = CNT_OUT_W'(k + 1);
                        r.status    = 1'b0;
                        break;
                    end
                end
            end
        endcase
        r.length = CNT_OUT_W'(shadow_len);
        return r;
    endfunction

    // Offer one beat, hold it until taken, then record what it should produce.
    task automatic send_op(input t_func f, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] v);
        t_list_result r;
        int           gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_W - FUNC_W - POS_W - VAL_W){1'b0}}, v, pos, f};
        do @(posedge i_clk); while (!o_s_tready);
        r = apply_list_op(f, pos, v);
        pending_results.push_back(r);
        ops_sent[int'(f)]++;
        if (!r.status)
            ops_ok[int'(f)]++;
        if (shadow_len > peak_len)
            peak_len = shadow_len;
    endtask

    // Stop offering and let every outstanding result drain (plus output latency).
    task automatic wait_all_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Capacity is only written with the pipe empty.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_all_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_cap = cap;
        capacity_writes++;
    endtask

    // Receiver: random ready gaps, plus the long hold-off when one is requested.
    initial begin : result_sink
        int rx_gap;
        rx_gap = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_m_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                rx_gap = $urandom_range(1, 12) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Scoreboard: each result beat against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_list_result want;
        t_list_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status     = o_m_tdata[0];
            got.read_value = o_m_tdata[32:1];
            got.found_pos  = o_m_tdata[39:33];
            got.length     = o_m_tdata[46:40];
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: tdata=%h", o_m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           $signed(want.read_value), $signed(got.read_value));
                    mismatches++;
                end
                if (got.found_pos !== want.found_pos) begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_pos, got.found_pos);
                    mismatches++;
                end
                if (got.length !== want.length) begin
                    $error("list_count: expected %0d, got %0d", want.length, got.length);
                    mismatches++;
                end
            end
        end
    end

    // Random position: mostly legal, with the end slots, one-past-end, zero and noise.
    function automatic logic [POS_W-1:0] pick_position(t_func f);
        int hi;
        if (f == FUNC_LOCATE)
            return POS_W'($urandom_range(0, 255));
        hi = (f == FUNC_INSERT) ? shadow_len + 1 : shadow_len;
        case ($urandom_range(0, 9))
            0:       return POS_W'($urandom_range(0, 255));
            1:       return '0;
            2:       return POS_W'(hi);
            3:       return POS_W'(hi + 1);
            default: return (hi < 1) ? POS_W'(1) : POS_W'($urandom_range(1, hi));
        endcase
    endfunction

    // Random value: locate mostly hunts for live entries; a small pool forces duplicates.
    function automatic logic [VAL_W-1:0] pick_value(t_func f);
        if (f == FUNC_LOCATE && shadow_len > 0 && $urandom_range(0, 9) < 7)
            return shadow_list[$urandom_range(0, shadow_len - 1)];
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return VAL_W'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // Weighted op mix; remaining weight splits between get and locate.
    task automatic run_list_phase(input int n_items, input int w_ins, input int w_del);
        t_func             f;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  v;
        int                r;
        repeat (n_items) begin
            r = $urandom_range(0, 99);
            if (r < w_ins)
                f = FUNC_INSERT;
            else if (r < w_ins + w_del)
                f = FUNC_DELETE;
            else if (r < w_ins + w_del + (100 - w_ins - w_del) / 2)
                f = FUNC_GET;
            else
                f = FUNC_LOCATE;
            pos = pick_position(f);
            v   = pick_value(f);
            send_op(f, pos, v);
        end
    endtask

    // Empty-list errors, bad positions, front/middle/end inserts, extremes.
    task automatic test_directed_ops();
        send_op(FUNC_GET,    8'd1,   32'd0);           // empty list
        send_op(FUNC_DELETE, 8'd1,   32'd0);
        send_op(FUNC_LOCATE, 8'd0,   32'd0);
        send_op(FUNC_INSERT, 8'd0,   32'd9);           // position zero
        send_op(FUNC_INSERT, 8'd2,   32'd9);           // past length+1
        send_op(FUNC_INSERT, 8'd1,   32'h8000_0000);
        send_op(FUNC_INSERT, 8'd2,   32'h7FFF_FFFF);   // append
        send_op(FUNC_INSERT, 8'd1,   32'hFFFF_FFFF);   // front
        send_op(FUNC_INSERT, 8'd2,   32'h0000_0000);   // middle
        send_op(FUNC_INSERT, 8'd5,   32'h1234_5678);   // length+1
        send_op(FUNC_INSERT, 8'd7,   32'd1);
        send_op(FUNC_INSERT, 8'd255, 32'd1);
        send_op(FUNC_GET,    8'd1,   32'd0);
        send_op(FUNC_GET,    8'd5,   32'd0);
        send_op(FUNC_GET,    8'd0,   32'd0);
        send_op(FUNC_GET,    8'd6,   32'd0);
        send_op(FUNC_GET,    8'd255, 32'd0);
        send_op(FUNC_LOCATE, 8'd0,   32'h7FFF_FFFF);
        send_op(FUNC_LOCATE, 8'd255, 32'h5555_5555);   // not found
        send_op(FUNC_INSERT, 8'd6,   32'hFFFF_FFFF);   // duplicate at tail
        send_op(FUNC_LOCATE, 8'd3,   32'hFFFF_FFFF);   // first match is the front
        send_op(FUNC_DELETE, 8'd0,   32'd0);
        send_op(FUNC_DELETE, 8'd7,   32'd0);
        send_op(FUNC_DELETE, 8'd6,   32'd0);           // last entry
        send_op(FUNC_DELETE, 8'd1,   32'd0);           // first entry
        send_op(FUNC_DELETE, 8'd255, 32'd0);
    endtask

    // Capacity zero, capacity under the current length, one, above DEPTH, full list.
    task automatic test_capacity_edges();
        set_capacity(7'd0);
        send_op(FUNC_INSERT, 8'd1, 32'd42);            // every insert full
        send_op(FUNC_GET,    8'd1, 32'd0);
        send_op(FUNC_LOCATE, 8'd0, 32'h8000_0000);

        set_capacity(7'd2);                            // below current length
        send_op(FUNC_INSERT, 8'd1, 32'd42);
        while (shadow_len > 1)
            send_op(FUNC_DELETE, 8'd1, 32'd0);
        send_op(FUNC_INSERT, 8'd1, 32'd42);
        send_op(FUNC_INSERT, 8'd1, 32'd43);

        set_capacity(7'd1);
        send_op(FUNC_INSERT, 8'd1, 32'd44);
        send_op(FUNC_GET,    8'd2, 32'd0);
        send_op(FUNC_DELETE, 8'd2, 32'd0);
        send_op(FUNC_INSERT, 8'd1, 32'd44);
        send_op(FUNC_DELETE, 8'd1, 32'd0);
        send_op(FUNC_INSERT, 8'd1, 32'd45);
        send_op(FUNC_INSERT, 8'd2, 32'd46);

        set_capacity(7'd127);                          // clipped to DEPTH
        while (shadow_len < LIST_DEPTH)
            send_op(FUNC_INSERT, POS_W'($urandom_range(1, shadow_len + 1)), $urandom);
        send_op(FUNC_INSERT, 8'd1,  32'd7);
        send_op(FUNC_INSERT, 8'd65, 32'd7);
        send_op(FUNC_GET,    8'd64, 32'd0);
        send_op(FUNC_LOCATE, 8'd0,  shadow_list[LIST_DEPTH-1]);

        set_capacity(7'd64);
        send_op(FUNC_INSERT, 8'd64, 32'd8);
        send_op(FUNC_DELETE, 8'd64, 32'd0);
        send_op(FUNC_INSERT, 8'd64, 32'd8);
    endtask

    // Long receiver hold-off fills the output stage; then a full drain mid-stream.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_hold    = 300;
        run_list_phase(25, 25, 25);
        wait_all_results();
        run_list_phase(25, 30, 30);
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        set_capacity(7'd64);
        run_list_phase(300, 45, 15);                   // grow to full
        run_list_phase(300, 15, 45);                   // shrink to empty
        set_capacity(7'd5);
        run_list_phase(300, 35, 35);
        set_capacity(7'd127);
        run_list_phase(300, 50, 20);
        set_capacity(CAP_W'($urandom_range(1, 64)));   // often under the length
        run_list_phase(250, 30, 30);
        // closing stretch runs back to back on both sides
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_capacity(7'd20);
        run_list_phase(250, 30, 30);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        test_capacity_edges();
        test_backpressure();
        test_random_traffic();

        wait_all_results();
        repeat (4) @(posedge i_clk);

        $display("ops sent ins/del/get/loc: %0d/%0d/%0d/%0d, succeeded: %0d/%0d/%0d/%0d",
                 ops_sent[0], ops_sent[1], ops_sent[2], ops_sent[3],
                 ops_ok[0], ops_ok[1], ops_ok[2], ops_ok[3]);
        $display("%0d result beats checked, peak length %0d, %0d capacity writes",
                 results_seen, peak_len, capacity_writes);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/pal_pkg.sv
design/pal_cell.sv
design/pal_prienc.sv
design/positional_array_list.sv
tb/sv/positional_array_list_tb.sv
